/* rtl/core/hbs_pkg.sv */
package hbs_pkg;

  // Store bounds used when the top level parameters are left at their defaults.
  localparam int MAX_COLUMNS_DEF = 256;
  localparam int MAX_ROWS_DEF    = 256;

  // Operation codes carried in the input item.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_DEPTH    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_X_PIX_PER_U  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_PIX_PER_U  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SCALE = 4'd7;

  // Division by three as a multiply by ceil(2^21/3) and a shift of 21.
  // It is exact for dividends below 2^21.
  localparam logic [19:0] RECIP3       = 20'd699051;
  localparam int          RECIP3_SHIFT = 21;

  typedef struct packed {
    logic               operation;
    logic [7:0]         pixel_column;
    logic [7:0]         pixel_row;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic signed [31:0] world_x;
    logic signed [31:0] world_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] ground_height;
    logic               inside_map;
  } out_item_t;

endpackage

/* rtl/core/heightmap_bilinear_sampler.sv */
// Height map sampler. Load items write one RGB pixel, converted to a signed Q16.16 height,
// into a store of four banked single-port-per-side memories split by column and row
// parity; query items map a world (x, z) point to a map cell and return the bilinear
// blend of its four corners, or 0 with inside_map low when the cell is outside the map.
// The block takes one item per clock: the four corners of any cell always fall in four
// different banks, so one read per bank per cycle covers a query. A query's result is
// registered at the output after stage 9; loads produce no result. Everything stalls
// together only while a finished result is held on the output. The store has no reset
// and no clearing pass: reading a never-written pixel gives an undefined height.
module heightmap_bilinear_sampler #(
  parameter int MAX_COLUMNS = hbs_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = hbs_pkg::MAX_ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  hbs_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output hbs_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);

  // Each bank holds every other column of every other row.
  localparam int HCOLS      = (MAX_COLUMNS + 1) / 2;
  localparam int HROWS      = (MAX_ROWS + 1) / 2;
  localparam int BANK_DEPTH = HCOLS * HROWS;
  localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int XW         = $clog2(MAX_COLUMNS);
  localparam int ZW         = $clog2(MAX_ROWS);

  typedef struct packed {
    logic        in_map;
    logic [11:0] pix;
    logic [15:0] frac;
  } axis_t;

  // Configuration registers.
  logic [8:0]         map_width_r, map_depth_r;
  logic signed [31:0] origin_x_r, origin_z_r, origin_y_r, height_scale_r;
  logic [31:0]        x_ppu_r, z_ppu_r;

  // The whole pipeline advances together unless a result is held on the output.
  logic       en;
  logic [9:1] v_r, q_r;

  // Stage registers.
  hbs_pkg::in_item_t  s1_r;
  logic [7:0]         s2_col_r, s3_col_r, s4_col_r, s5_col_r;
  logic [7:0]         s2_row_r, s3_row_r, s4_row_r, s5_row_r;
  logic [16:0]        s2_q_r;
  logic               s2_neg_r;
  logic [31:0]        s2_mx_r, s2_mz_r;
  logic               s2_nx_r, s2_nz_r, s3_nx_r, s3_nz_r, s4_nx_r, s4_nz_r;
  logic signed [32:0] s3_t_r;
  logic [47:0]        s3_pxh_r, s3_pxl_r, s3_pzh_r, s3_pzl_r;
  logic signed [48:0] s4_ph_r, s4_pl_r;
  logic [63:0]        s4_prodx_r, s4_prodz_r;
  logic signed [31:0] s5_wdata_r;
  logic               s5_in_r, s6_in_r, s7_in_r, s8_in_r, s9_in_r;
  logic [XW-1:0]      s5_xc_r;
  logic [ZW-1:0]      s5_zc_r;
  logic [15:0]        s5_fx_r, s5_fz_r, s6_fx_r, s6_fz_r, s7_fz_r, s8_fz_r;
  logic               s6_xp_r, s6_zp_r;
  logic signed [31:0] bank_q_r [4];
  logic signed [49:0] s7_p_r [4];
  logic signed [31:0] s8_a_r, s8_b_r;
  logic signed [49:0] s9_p0_r, s9_p1_r;
  logic               out_valid_r;
  hbs_pkg::out_item_t out_r;

  // Combinational values between stages.
  logic [12:0]        size_x, size_z;
  logic [9:0]         rgb_sum;
  logic signed [10:0] rgb_off;
  logic [8:0]         rgb_mag;
  logic [17:0]        div_in;
  logic [37:0]        div_prod;
  logic signed [32:0] dx, dz, base_h;
  logic signed [65:0] load_acc, load_rnd;
  logic signed [31:0] load_sat;
  axis_t              ax_x, ax_z;
  logic [16:0]        wx_lo, wz_lo;
  logic signed [50:0] row0_sum, row1_sum, col_sum;
  logic signed [31:0] height_c;
  logic               rd_en, wr_ok;
  logic [1:0]         wr_bank;
  logic [BAW-1:0]     wr_addr;
  logic [3:0]         we_bank;

  function automatic axis_t to_pix(input logic [63:0] prod, input logic neg,
                                   input logic [12:0] size);
    logic [64:0] off;
    logic [64:0] pos;
    axis_t       res;
    off        = 65'(size) << 31;
    res.in_map = 1'b1;
    if (neg) begin
      if (65'(prod) > off) res.in_map = 1'b0;
      pos = off - 65'(prod);
    end else begin
      pos = off + 65'(prod);
      if (pos[64]) res.in_map = 1'b0;
    end
    if (size < 13'd2) res.in_map = 1'b0;
    if (pos[63:32] >= 32'(size) - 32'd1) res.in_map = 1'b0;
    res.pix  = pos[43:32];
    res.frac = pos[31:16];
    return res;
  endfunction

  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The user must write configuration only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r    <= 9'd256;
      map_depth_r    <= 9'd256;
      origin_x_r     <= '0;
      origin_z_r     <= '0;
      origin_y_r     <= '0;
      x_ppu_r        <= 32'd65536;
      z_ppu_r        <= 32'd65536;
      height_scale_r <= 32'sd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hbs_pkg::CFG_MAP_WIDTH:    map_width_r    <= cfg_data[8:0];
        hbs_pkg::CFG_MAP_DEPTH:    map_depth_r    <= cfg_data[8:0];
        hbs_pkg::CFG_ORIGIN_X:     origin_x_r     <= cfg_data;
        hbs_pkg::CFG_ORIGIN_Z:     origin_z_r     <= cfg_data;
        hbs_pkg::CFG_ORIGIN_Y:     origin_y_r     <= cfg_data;
        hbs_pkg::CFG_X_PIX_PER_U:  x_ppu_r        <= cfg_data;
        hbs_pkg::CFG_Z_PIX_PER_U:  z_ppu_r        <= cfg_data;
        hbs_pkg::CFG_HEIGHT_SCALE: height_scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // A map larger than the store acts as the store size.
  assign size_x = (32'(map_width_r) > 32'(MAX_COLUMNS)) ? 13'(MAX_COLUMNS) : 13'(map_width_r);
  assign size_z = (32'(map_depth_r) > 32'(MAX_ROWS)) ? 13'(MAX_ROWS) : 13'(map_depth_r);

  // Stage 1 to 2: the load divides the centered color sum, scaled by 512, by three; the
  // query forms the signed distance from the terrain center on each axis.
  always_comb begin
    rgb_sum  = 10'(s1_r.red) + 10'(s1_r.green) + 10'(s1_r.blue);
    rgb_off  = $signed({1'b0, rgb_sum}) - 11'sd384;
    rgb_mag  = rgb_off[10] ? 9'(-rgb_off) : rgb_off[8:0];
    div_in   = {rgb_mag, 9'b0} + 18'd1;
    div_prod = 38'(div_in) * 38'(hbs_pkg::RECIP3);
    dx       = 33'(s1_r.world_x) - 33'(origin_x_r);
    dz       = 33'(s1_r.world_z) - 33'(origin_z_r);
  end

  // Stage 2 to 3: signed base height plus offset; distance partial products.
  assign base_h = s2_neg_r ? -33'(signed'({1'b0, s2_q_r})) : 33'(signed'({1'b0, s2_q_r}));

  // Stage 4 to 5: rounding and saturation of the scaled height; the axis mapping.
  always_comb begin
    load_acc = (66'(s4_ph_r) <<< 16) + 66'(s4_pl_r) + 66'sd32768;
    load_rnd = load_acc >>> 16;
    if (load_rnd > 66'sd2147483647) begin
      load_sat = 32'sh7fffffff;
    end else if (load_rnd < -66'sd2147483648) begin
      load_sat = 32'sh80000000;
    end else begin
      load_sat = load_rnd[31:0];
    end
    ax_x = to_pix(s4_prodx_r, s4_nx_r, size_x);
    ax_z = to_pix(s4_prodz_r, s4_nz_r, size_z);
  end

  // Stage 5: a load writes its bank, a query reads one word from every bank. Both
  // happen in the same stage, so a query always sees every load transferred before it.
  assign rd_en   = en && v_r[5] && q_r[5];
  assign wr_ok   = (32'(s5_col_r) < 32'(MAX_COLUMNS)) && (32'(s5_row_r) < 32'(MAX_ROWS));
  assign wr_bank = {s5_row_r[0], s5_col_r[0]};
  assign wr_addr = BAW'(32'(s5_row_r >> 1) * 32'(HCOLS) + 32'(s5_col_r >> 1));

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      we_bank[b] = en && v_r[5] && !q_r[5] && wr_ok && (wr_bank == 2'(b));
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic CP = 1'(b % 2);
    localparam logic RP = 1'(b / 2);
    logic signed [31:0] mem [BANK_DEPTH];
    logic [XW:0]        qcol;
    logic [ZW:0]        qrow;
    logic [BAW-1:0]     raddr;

    always_comb begin
      qcol  = (s5_xc_r[0] == CP) ? {1'b0, s5_xc_r} : {1'b0, s5_xc_r} + 1'b1;
      qrow  = (s5_zc_r[0] == RP) ? {1'b0, s5_zc_r} : {1'b0, s5_zc_r} + 1'b1;
      raddr = BAW'(32'(qrow >> 1) * 32'(HCOLS) + 32'(qcol >> 1));
    end

    always_ff @(posedge clk) begin
      if (we_bank[b]) begin
        mem[wr_addr] <= s5_wdata_r;
      end
      if (rd_en) begin
        bank_q_r[b] <= mem[raddr];
      end
    end
  end

  // Stage 6 to 10: blend along x in both rows, then along z.
  assign wx_lo    = 17'h10000 - {1'b0, s6_fx_r};
  assign wz_lo    = 17'h10000 - {1'b0, s8_fz_r};
  assign row0_sum = 51'(s7_p_r[0]) + 51'(s7_p_r[1]) + 51'sd32768;
  assign row1_sum = 51'(s7_p_r[2]) + 51'(s7_p_r[3]) + 51'sd32768;
  assign col_sum  = 51'(s9_p0_r) + 51'(s9_p1_r) + 51'sd32768;
  assign height_c = col_sum[47:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      q_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[8:1], in_valid};
      q_r         <= {q_r[8:1], in_data.operation == hbs_pkg::OP_QUERY};
      out_valid_r <= v_r[9] && q_r[9];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r       <= in_data;
      // stage 2
      s2_col_r   <= s1_r.pixel_column;
      s2_row_r   <= s1_r.pixel_row;
      s2_q_r     <= div_prod[hbs_pkg::RECIP3_SHIFT +: 17];
      s2_neg_r   <= rgb_off[10];
      s2_nx_r    <= dx[32];
      s2_nz_r    <= dz[32];
      s2_mx_r    <= dx[32] ? 32'(-dx) : dx[31:0];
      s2_mz_r    <= dz[32] ? 32'(-dz) : dz[31:0];
      // stage 3
      s3_col_r   <= s2_col_r;
      s3_row_r   <= s2_row_r;
      s3_t_r     <= base_h + 33'(origin_y_r);
      s3_nx_r    <= s2_nx_r;
      s3_nz_r    <= s2_nz_r;
      s3_pxh_r   <= 48'(s2_mx_r[31:16]) * 48'(x_ppu_r);
      s3_pxl_r   <= 48'(s2_mx_r[15:0]) * 48'(x_ppu_r);
      s3_pzh_r   <= 48'(s2_mz_r[31:16]) * 48'(z_ppu_r);
      s3_pzl_r   <= 48'(s2_mz_r[15:0]) * 48'(z_ppu_r);
      // stage 4
      s4_col_r   <= s3_col_r;
      s4_row_r   <= s3_row_r;
      s4_ph_r    <= $signed(s3_t_r[32:16]) * height_scale_r;
      s4_pl_r    <= $signed({1'b0, s3_t_r[15:0]}) * height_scale_r;
      s4_nx_r    <= s3_nx_r;
      s4_nz_r    <= s3_nz_r;
      s4_prodx_r <= {s3_pxh_r, 16'b0} + 64'(s3_pxl_r);
      s4_prodz_r <= {s3_pzh_r, 16'b0} + 64'(s3_pzl_r);
      // stage 5
      s5_col_r   <= s4_col_r;
      s5_row_r   <= s4_row_r;
      s5_wdata_r <= load_sat;
      s5_in_r    <= ax_x.in_map && ax_z.in_map;
      s5_xc_r    <= ax_x.pix[XW-1:0];
      s5_zc_r    <= ax_z.pix[ZW-1:0];
      s5_fx_r    <= ax_x.frac;
      s5_fz_r    <= ax_z.frac;
      // stage 6
      s6_in_r    <= s5_in_r;
      s6_fx_r    <= s5_fx_r;
      s6_fz_r    <= s5_fz_r;
      s6_xp_r    <= s5_xc_r[0];
      s6_zp_r    <= s5_zc_r[0];
      // stage 7: banks are indexed by {row parity, column parity}
      s7_in_r    <= s6_in_r;
      s7_fz_r    <= s6_fz_r;
      s7_p_r[0]  <= bank_q_r[{s6_zp_r, s6_xp_r}] * $signed({1'b0, wx_lo});
      s7_p_r[1]  <= bank_q_r[{s6_zp_r, !s6_xp_r}] * $signed({2'b0, s6_fx_r});
      s7_p_r[2]  <= bank_q_r[{!s6_zp_r, s6_xp_r}] * $signed({1'b0, wx_lo});
      s7_p_r[3]  <= bank_q_r[{!s6_zp_r, !s6_xp_r}] * $signed({2'b0, s6_fx_r});
      // stage 8
      s8_in_r    <= s7_in_r;
      s8_fz_r    <= s7_fz_r;
      s8_a_r     <= row0_sum[47:16];
      s8_b_r     <= row1_sum[47:16];
      // stage 9
      s9_in_r    <= s8_in_r;
      s9_p0_r    <= s8_a_r * $signed({1'b0, wz_lo});
      s9_p1_r    <= s8_b_r * $signed({2'b0, s8_fz_r});
      // output
      out_r.inside_map    <= s9_in_r;
      out_r.ground_height <= s9_in_r ? height_c : 32'sd0;
    end
  end

  // A point outside the map always reports zero height.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.inside_map |-> out_data.ground_height == 32'sd0)
    else $error("outside result carries a nonzero height");

  // A new result only comes from a query leaving the last blend stage.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(v_r[9] && q_r[9]))
    else $error("result without a query behind it");

  // A frozen pipeline neither writes nor reads the banks.
  assert property (@(posedge clk) disable iff (!rst_n)
    !en |-> (we_bank == 4'b0) && !rd_en)
    else $error("bank access while stalled");

  // A stalled pipeline keeps the read data of banks 0 and 3 for the query waiting behind it.
  assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(bank_q_r[0]) && $stable(bank_q_r[3]))
    else $error("bank read data changed during stall");

endmodule
